// ----- rtl/transmit_request_framer_assert.svh -----
// assertion macros for the frame serializer
`ifndef TRANSMIT_REQUEST_FRAMER_ASSERT_SVH
`define TRANSMIT_REQUEST_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off while rst is high
`define TFR_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define TFR_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`else

`define TFR_ASSERT_IMP(label, pre, post, msg)
`define TFR_ASSERT_NXT(label, pre, post, msg)

`endif

`endif

// ----- rtl/tfr_pkg.sv -----
package tfr_pkg;

  // item opcodes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // frame constants
  localparam int unsigned DEFAULT_MAX_PAYLOAD = 237;
  localparam logic [7:0]  HEADER_LEN          = 8'd14;
  localparam logic [7:0]  DELIM_RESET         = 8'd126;

  // configuration port
  localparam int unsigned PADDR_W             = 3;
  localparam logic        REG_START_DELIMITER = 1'b0;

  // byte positions within a start item
  localparam int unsigned POS_W        = 5;
  localparam logic [4:0]  POS_DELIM    = 5'd0;
  localparam logic [4:0]  POS_LEN_HI   = 5'd1;
  localparam logic [4:0]  POS_LEN_LO   = 5'd2;
  localparam logic [4:0]  POS_HDR_LAST = 5'd16;
  localparam logic [4:0]  POS_CSUM     = 5'd17;
  localparam logic [4:0]  POS_HDR_FIRST = 5'd3;

  // byte positions within a payload item
  localparam logic [4:0]  POS_PAY_DATA = 5'd0;
  localparam logic [4:0]  POS_PAY_CSUM = 5'd1;

  // one accepted input item
  typedef struct packed {
    logic        op;
    logic [7:0]  frame_type;
    logic [7:0]  frame_ident;
    logic [31:0] dest_high;
    logic [31:0] dest_low;
    logic [15:0] net_addr;
    logic [7:0]  hop_radius;
    logic [7:0]  tx_options;
    logic [7:0]  payload_count;
    logic [7:0]  payload_byte;
  } item_t;

  // one output word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;
  } word_t;

  // sequencer status toward the top level
  typedef struct packed {
    logic busy;
    logic push;
  } seq_stat_t;

endpackage

// ----- rtl/tfr_if.sv -----
// input item channel
interface tfr_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  frame_type;
  logic [7:0]  frame_ident;
  logic [31:0] dest_high;
  logic [31:0] dest_low;
  logic [15:0] net_addr;
  logic [7:0]  hop_radius;
  logic [7:0]  tx_options;
  logic [7:0]  payload_count;
  logic [7:0]  payload_byte;

  modport source (
    output valid, op, frame_type, frame_ident, dest_high, dest_low, net_addr,
           hop_radius, tx_options, payload_count, payload_byte,
    input  ready
  );
  modport sink (
    input  valid, op, frame_type, frame_ident, dest_high, dest_low, net_addr,
           hop_radius, tx_options, payload_count, payload_byte,
    output ready
  );
endinterface

// serialized byte channel
interface tfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_done;

  modport source (
    output valid, out_byte, run_last, frame_done,
    input  ready
  );
  modport sink (
    input  valid, out_byte, run_last, frame_done,
    output ready
  );
endinterface

// ----- rtl/transmit_request_framer.sv -----
// transmit request framer: one byte word per cycle on the output channel while the receiver holds ready
// the first byte of an accepted item passes through the item register, then the output register
// a start item occupies the sequencer for 17 output bytes, 18 with an empty payload
// a payload item emits its byte, and also the checksum when it closes the frame; an ignored one emits nothing
// throughput is set by the single byte-wide output register, one word per cycle while ready is held high
// reset (rst, synchronous): frame state idle and cleared, delimiter back to 126
module transmit_request_framer #(
  parameter int unsigned MAX_PAYLOAD = tfr_pkg::DEFAULT_MAX_PAYLOAD
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tfr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  tfr_item_if.sink                     item,
  tfr_byte_if.source                   stream
);
  import tfr_pkg::*;

  logic       [7:0] delim;
  logic             cfg_wr;
  item_t            item_d;
  logic             take;
  logic             load;
  logic             out_free;
  word_t            seq_word;
  word_t            out_word;
  seq_stat_t        seq_stat;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_START_DELIMITER);
  assign prdata = (paddr[2] == REG_START_DELIMITER) ? {24'd0, delim} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim <= DELIM_RESET;
    end else if (cfg_wr) begin
      delim <= pwdata[7:0];
    end
  end

  // input channel
  assign item_d.op            = item.op;
  assign item_d.frame_type    = item.frame_type;
  assign item_d.frame_ident   = item.frame_ident;
  assign item_d.dest_high     = item.dest_high;
  assign item_d.dest_low      = item.dest_low;
  assign item_d.net_addr      = item.net_addr;
  assign item_d.hop_radius    = item.hop_radius;
  assign item_d.tx_options    = item.tx_options;
  assign item_d.payload_count = item.payload_count;
  assign item_d.payload_byte  = item.payload_byte;
  assign item.ready           = take;
  assign load                 = item.valid && take;

  tfr_seq #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .item_d   (item_d),
    .delim    (delim),
    .out_free (out_free),
    .take     (take),
    .word     (seq_word),
    .stat     (seq_stat)
  );

  tfr_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (seq_stat.push),
    .word_d   (seq_word),
    .ready    (stream.ready),
    .out_free (out_free),
    .valid    (stream.valid),
    .word_q   (out_word)
  );

  // output channel
  assign stream.out_byte   = out_word.out_byte;
  assign stream.run_last   = out_word.run_last;
  assign stream.frame_done = out_word.frame_done;

  // checks
  `include "transmit_request_framer_assert.svh"

  `TFR_ASSERT_IMP(a_push_free, seq_stat.push, out_free, "word pushed into a full output register")
  `TFR_ASSERT_IMP(a_idle_ready, !seq_stat.busy, item.ready, "idle sequencer refuses an item")
  `TFR_ASSERT_IMP(a_csum_last, stream.valid && stream.frame_done, stream.run_last, "checksum not last word")
  `TFR_ASSERT_NXT(a_load_busy, load, seq_stat.busy, "accepted item did not occupy the sequencer")

endmodule

// ----- rtl/tfr_seq.sv -----
module tfr_seq #(
  parameter int unsigned MAX_PAYLOAD = tfr_pkg::DEFAULT_MAX_PAYLOAD
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  tfr_pkg::item_t     item_d,
  input  logic [7:0]         delim,
  input  logic               out_free,
  output logic               take,
  output tfr_pkg::word_t     word,
  output tfr_pkg::seq_stat_t stat
);
  import tfr_pkg::*;

  localparam logic [7:0] MAX_CNT = 8'(MAX_PAYLOAD);

  logic             busy;
  item_t            cur;
  logic [POS_W-1:0] pos;
  logic [7:0]       running_sum;
  logic [7:0]       bytes_left;
  logic             in_frame;

  logic             is_start;
  logic             has_byte;
  logic             last_byte;
  logic             emit;
  logic             finish;
  logic [15:0]      frame_len;
  logic [7:0]       hdr [14];
  logic [3:0]       hdr_sel;
  logic [7:0]       byte_sel;
  logic [7:0]       cnt_sat;
  item_t            item_sat;

  // saturate the payload count as the item comes in
  assign cnt_sat = (item_d.payload_count > MAX_CNT) ? MAX_CNT : item_d.payload_count;

  always_comb begin
    item_sat               = item_d;
    item_sat.payload_count = cnt_sat;
  end

  // header bytes in wire order
  always_comb begin
    hdr[0]  = cur.frame_type;
    hdr[1]  = cur.frame_ident;
    hdr[2]  = cur.dest_high[31:24];
    hdr[3]  = cur.dest_high[23:16];
    hdr[4]  = cur.dest_high[15:8];
    hdr[5]  = cur.dest_high[7:0];
    hdr[6]  = cur.dest_low[31:24];
    hdr[7]  = cur.dest_low[23:16];
    hdr[8]  = cur.dest_low[15:8];
    hdr[9]  = cur.dest_low[7:0];
    hdr[10] = cur.net_addr[15:8];
    hdr[11] = cur.net_addr[7:0];
    hdr[12] = cur.hop_radius;
    hdr[13] = cur.tx_options;
  end

  assign frame_len = 16'(HEADER_LEN) + 16'(cur.payload_count);
  assign hdr_sel   = 4'(pos - POS_HDR_FIRST);
  assign is_start  = (cur.op == OP_START);
  // a payload word outside a frame produces nothing
  assign has_byte  = is_start || in_frame;

  // byte select for the current position
  always_comb begin
    if (is_start) begin
      unique case (pos)
        POS_DELIM:  byte_sel = delim;
        POS_LEN_HI: byte_sel = frame_len[15:8];
        POS_LEN_LO: byte_sel = frame_len[7:0];
        POS_CSUM:   byte_sel = ~running_sum;
        default: begin
          byte_sel = (pos <= POS_HDR_LAST) ? hdr[hdr_sel] : 8'h00;
        end
      endcase
    end else begin
      byte_sel = (pos == POS_PAY_CSUM) ? ~running_sum : cur.payload_byte;
    end
  end

  // last byte this item produces
  always_comb begin
    if (is_start) begin
      last_byte = (cur.payload_count == 8'd0) ? (pos == POS_CSUM) : (pos == POS_HDR_LAST);
    end else begin
      last_byte = (bytes_left == 8'd1) ? (pos == POS_PAY_CSUM) : 1'b1;
    end
  end

  assign emit   = busy && has_byte && out_free;
  assign finish = busy && (!has_byte || (emit && last_byte));
  assign take   = !busy || finish;

  assign word.out_byte   = byte_sel;
  assign word.run_last   = last_byte;
  assign word.frame_done = is_start ? (pos == POS_CSUM) : (pos == POS_PAY_CSUM);

  assign stat.busy = busy;
  assign stat.push = emit;

  // item register and position counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= POS_DELIM;
    end else if (load) begin
      busy <= 1'b1;
      pos  <= POS_DELIM;
    end else begin
      if (finish) begin
        busy <= 1'b0;
      end
      if (emit) begin
        pos <= last_byte ? POS_DELIM : pos + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= item_sat;
    end
  end

  // frame state: checksum accumulator, remaining payload, frame open
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 8'd0;
      bytes_left  <= 8'd0;
      in_frame    <= 1'b0;
    end else if (emit) begin
      if (is_start) begin
        if (pos == POS_DELIM || pos == POS_CSUM) begin
          running_sum <= 8'd0;
        end else if (pos >= POS_HDR_FIRST && pos <= POS_HDR_LAST) begin
          running_sum <= running_sum + byte_sel;
        end
        if (last_byte) begin
          bytes_left <= cur.payload_count;
          in_frame   <= (cur.payload_count != 8'd0);
        end
      end else if (pos == POS_PAY_DATA) begin
        running_sum <= running_sum + cur.payload_byte;
        bytes_left  <= bytes_left - 8'd1;
      end else begin
        running_sum <= 8'd0;
        in_frame    <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/tfr_out_reg.sv -----
module tfr_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tfr_pkg::word_t word_d,
  input  logic           ready,
  output logic           out_free,
  output logic           valid,
  output tfr_pkg::word_t word_q
);
  import tfr_pkg::*;

  // slot frees when empty or being drained this cycle
  assign out_free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && push) begin
      word_q <= word_d;
    end
  end

endmodule

// ----- tb/tb_transmit_request_framer.sv -----
`timescale 1ns / 100ps

module tb_transmit_request_framer;
  import tfr_pkg::*;

  localparam int unsigned MAX_COUNT = DEFAULT_MAX_PAYLOAD;
  localparam logic [7:0] CSUM_BASE = 8'hFF;
  localparam logic [PADDR_W-1:0] DELIM_ADDR = PADDR_W'(4 * REG_START_DELIMITER);
  // extra wait after the owed bytes drain, covering the output register and an ignored payload word
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PRINT_CAP = 40;

  // frame predictor and queue of bytes still owed by the block
  class frame_tracker;
    logic [7:0] delimiter;
    logic [7:0] frame_sum;
    logic [7:0] bytes_owed;
    logic framing;
    word_t bytes_due[$];
    int errors;

    function new();
      delimiter = DELIM_RESET;
      frame_sum = '0;
      bytes_owed = '0;
      framing = 1'b0;
      errors = 0;
    endfunction

    function void due(logic [7:0] b, logic last, logic done);
      word_t w;
      w.out_byte = b;
      w.run_last = last;
      w.frame_done = done;
      bytes_due.push_back(w);
    endfunction

    function int pending();
      return bytes_due.size();
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    // work out the bytes one accepted item causes
    function void note_item(item_t it);
      logic [7:0] cnt;
      logic [15:0] len;
      logic [111:0] hdr;
      logic [7:0] b;
      logic [7:0] sum;
      if (it.op == OP_START) begin
        cnt = (it.payload_count > MAX_COUNT) ? 8'(MAX_COUNT) : it.payload_count;
        len = 16'(HEADER_LEN) + 16'(cnt);
        hdr = {it.frame_type, it.frame_ident, it.dest_high, it.dest_low, it.net_addr,
               it.hop_radius, it.tx_options};
        due(delimiter, 1'b0, 1'b0);
        due(len[15:8], 1'b0, 1'b0);
        due(len[7:0], 1'b0, 1'b0);
        sum = '0;
        for (int i = 0; i < 14; i++) begin
          b = hdr[111 - 8 * i -: 8];
          sum = sum + b;
          due(b, (i == 13) && (cnt != 0), 1'b0);
        end
        // empty payload closes the frame straight away
        if (cnt == 0) begin
          due(CSUM_BASE - sum, 1'b1, 1'b1);
          frame_sum = '0;
          bytes_owed = '0;
          framing = 1'b0;
        end else begin
          frame_sum = sum;
          bytes_owed = cnt;
          framing = 1'b1;
        end
      end else if (framing) begin
        frame_sum = frame_sum + it.payload_byte;
        bytes_owed = bytes_owed - 8'd1;
        if (bytes_owed == 0) begin
          due(it.payload_byte, 1'b0, 1'b0);
          due(CSUM_BASE - frame_sum, 1'b1, 1'b1);
          frame_sum = '0;
          framing = 1'b0;
        end else begin
          due(it.payload_byte, 1'b1, 1'b0);
        end
      end
    endfunction

    // compare one output word with the oldest owed byte
    function void check_word(word_t got);
      word_t want;
      if (bytes_due.size() == 0) begin
        report($sformatf("byte %h with nothing owed", got.out_byte));
        return;
      end
      want = bytes_due.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
      if (got.run_last !== want.run_last)
        report($sformatf("run_last %b, want %b (byte %h)", got.run_last, want.run_last,
                         want.out_byte));
      if (got.frame_done !== want.frame_done)
        report($sformatf("frame_done %b, want %b (byte %h)", got.frame_done,
                         want.frame_done, want.out_byte));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic src_calm = 1'b0;

  frame_tracker tracker;

  tfr_item_if item_ch ();
  tfr_byte_if byte_ch ();

  transmit_request_framer i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item_ch),
    .stream  (byte_ch)
  );

  always #4 clk = ~clk;

  function automatic item_t start_item(logic [7:0] ftype, logic [7:0] ident,
                                       logic [31:0] dhigh, logic [31:0] dlow,
                                       logic [15:0] naddr, logic [7:0] radius,
                                       logic [7:0] opts, logic [7:0] count);
    item_t it;
    it.op = OP_START;
    it.frame_type = ftype;
    it.frame_ident = ident;
    it.dest_high = dhigh;
    it.dest_low = dlow;
    it.net_addr = naddr;
    it.hop_radius = radius;
    it.tx_options = opts;
    it.payload_count = count;
    it.payload_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic item_t rand_start(logic [7:0] count);
    return start_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom,
                      $urandom, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), count);
  endfunction

  // header fields stay random on payload words, the block must not care
  function automatic item_t payload_item(logic [7:0] b);
    item_t it;
    it = rand_start(8'($urandom_range(0, 255)));
    it.op = OP_PAYLOAD;
    it.payload_byte = b;
    return it;
  endfunction

  function automatic logic [7:0] pick_count();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return 8'd0;
    if (r < 17) return 8'($urandom_range(1, 8));
    return 8'($urandom_range(9, 40));
  endfunction

  // present one item, hold it until accepted
  task automatic send_item(input item_t it);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.op <= it.op;
    item_ch.frame_type <= it.frame_type;
    item_ch.frame_ident <= it.frame_ident;
    item_ch.dest_high <= it.dest_high;
    item_ch.dest_low <= it.dest_low;
    item_ch.net_addr <= it.net_addr;
    item_ch.hop_radius <= it.hop_radius;
    item_ch.tx_options <= it.tx_options;
    item_ch.payload_count <= it.payload_count;
    item_ch.payload_byte <= it.payload_byte;
    do @(posedge clk); while (!item_ch.ready);
    tracker.note_item(it);
  endtask

  // stop sending and let every owed byte drain out
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup cycle then access cycle
  task automatic write_delimiter(input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DELIM_ADDR;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.delimiter = value;
  endtask

  // one frame: mostly complete, sometimes cut short or followed by stray bytes
  task automatic run_frame(input logic [7:0] count, input bit whole, inout int budget);
    int owed;
    int mode;
    owed = (count > MAX_COUNT) ? MAX_COUNT : count;
    mode = whole ? 2 : $urandom_range(0, 9);
    src_calm = ($urandom_range(0, 3) == 0);
    send_item(rand_start(count));
    budget--;
    // cut short: the next start abandons this frame
    if (mode == 0 && owed > 0) owed = $urandom_range(0, owed - 1);
    repeat (owed) begin
      send_item(payload_item(8'($urandom_range(0, 255))));
      budget--;
    end
    // stray bytes after the checksum are dropped
    if (mode == 1)
      repeat ($urandom_range(1, 2)) send_item(payload_item(8'($urandom_range(0, 255))));
  endtask

  task automatic random_phase(input int quota);
    int left;
    left = quota;
    while (left > 0) run_frame(pick_count(), 1'b0, left);
  endtask

  // output side: random stalls with calm stretches
  initial begin : word_sink
    int stall;
    int served;
    logic quiet;
    word_t w;
    served = 0;
    quiet = 1'b0;
    byte_ch.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (served % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      stall = quiet ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        byte_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      byte_ch.ready <= 1'b1;
      do @(posedge clk); while (!byte_ch.valid);
      w.out_byte = byte_ch.out_byte;
      w.run_last = byte_ch.run_last;
      w.frame_done = byte_ch.frame_done;
      tracker.check_word(w);
      served++;
    end
  end

  // run limit
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    tracker = new();
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_ch.valid = 1'b0;
    item_ch.op = OP_START;
    item_ch.frame_type = '0;
    item_ch.frame_ident = '0;
    item_ch.dest_high = '0;
    item_ch.dest_low = '0;
    item_ch.net_addr = '0;
    item_ch.hop_radius = '0;
    item_ch.tx_options = '0;
    item_ch.payload_count = '0;
    item_ch.payload_byte = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset delimiter
    // payload while idle is dropped
    send_item(payload_item(8'h5A));
    // empty payload, all zero and all one fields
    send_item(start_item(8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 8'h00, 8'h00, 8'd0));
    send_item(start_item(8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF,
                         8'hFF, 8'd0));
    // count saturates, then a new start abandons the frame
    send_item(start_item(8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF,
                         8'hFF, 8'hFF));
    send_item(payload_item(8'hFF));
    send_item(payload_item(8'hFF));
    send_item(start_item(8'h10, 8'h01, 32'h0013_A200, 32'h40A1_B2C3, 16'hFFFE, 8'h00,
                         8'h00, 8'd1));
    send_item(payload_item(8'h00));
    send_item(payload_item(8'hFF));
    // just above and at the maximum count, each abandoned
    send_item(rand_start(8'd238));
    send_item(payload_item(8'h81));
    send_item(rand_start(8'd237));
    send_item(payload_item(8'h7E));
    // running sum wraps
    send_item(rand_start(8'd2));
    send_item(payload_item(8'hFF));
    send_item(payload_item(8'h01));
    send_item(start_item(8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 8'h00, 8'h00, 8'd3));
    repeat (3) send_item(payload_item(8'h00));
    settle();

    // zero delimiter, a saturated frame cut short by the next start
    write_delimiter(8'h00);
    send_item(rand_start(8'($urandom_range(238, 255))));
    repeat (3) send_item(payload_item(8'($urandom_range(0, 255))));
    random_phase(50);
    settle();

    write_delimiter(8'hFF);
    random_phase(50);
    settle();

    write_delimiter(8'($urandom_range(1, 254)));
    random_phase(50);
    settle();

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
